[src/sorted_list_insert_delete_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the sorted list block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// Check a property on every rising edge outside reset
`define SLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define SLI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg
// Beat types and codes for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic                    command;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      entry_count;
    logic signed [VAL_W-1:0] smallest;
    logic signed [VAL_W-1:0] largest;
  } out_item_t;

endpackage

[src/sli_mem.sv]
// ----------------------------------------------------------------------------
// sli_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sli_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [sli_pkg::VAL_W-1:0] wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic signed [sli_pkg::VAL_W-1:0] rdata
);

  logic signed [sli_pkg::VAL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sli_ctrl.sv]
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer walking the entry store with one shared comparator.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_macros.svh"

module sli_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beat
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sli_pkg::in_item_t                in_data,
  // result towards output register
  output logic                             res_valid,
  input  logic                             res_ready,
  output sli_pkg::out_item_t               res_data,
  // store port
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic signed [sli_pkg::VAL_W-1:0] mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  logic signed [sli_pkg::VAL_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_LAST,
    S_DEL_RD,
    S_DEL_CMP,
    S_FIN_LO,
    S_FIN_HI,
    S_DONE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CW-1:0]                    held_r, held_nxt;
  logic [AW-1:0]                    idx_r, idx_nxt;
  logic                             found_r, found_nxt;
  logic                             cmd_r, cmd_nxt;
  logic signed [sli_pkg::VAL_W-1:0] val_r, val_nxt;
  logic signed [sli_pkg::VAL_W-1:0] small_r, small_nxt;
  logic [sli_pkg::STAT_W-1:0]       status_r, status_nxt;

  logic [CW-1:0] held_m1;
  logic [AW-1:0] last_idx;
  logic          gt;
  logic          eq;
  logic          hit;
  logic          full;

  assign held_m1  = held_r - CW'(1);
  assign last_idx = held_m1[AW-1:0];
  assign full     = (held_r == CW'(CAPACITY));

  // Shared compare unit: stored entry against the operand
  assign gt  = (mem_rdata > val_r);
  assign eq  = (mem_rdata == val_r);
  assign hit = found_r | eq;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // Result fields; empty list shows zero at both ends
  always_comb begin
    res_data.status      = status_r;
    res_data.entry_count = sli_pkg::COUNT_W'(held_r);
    res_data.smallest    = (held_r == '0) ? '0 : small_r;
    res_data.largest     = (held_r == '0) ? '0 : mem_rdata;
  end

  // Next state and store access
  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    small_nxt  = small_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.command;
          val_nxt    = in_data.value;
          found_nxt  = 1'b0;
          status_nxt = sli_pkg::ST_DONE;
          if (in_data.command == sli_pkg::CMD_INSERT) begin
            if (full) begin
              status_nxt = sli_pkg::ST_FULL;
              state_nxt  = S_FIN_LO;
            end else if (held_r == '0) begin
              mem_we    = 1'b1;
              mem_wdata = in_data.value;
              held_nxt  = held_r + CW'(1);
              state_nxt = S_FIN_LO;
            end else begin
              idx_nxt   = last_idx;
              state_nxt = S_INS_RD;
            end
          end else begin
            if (held_r == '0) begin
              status_nxt = sli_pkg::ST_NOTFOUND;
              state_nxt  = S_FIN_LO;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_DEL_RD;
            end
          end
        end
      end

      S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = S_INS_CMP;
      end

      // Walk down from the tail, moving larger entries up one place
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + AW'(1);
        if (gt) begin
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          mem_wdata = val_r;
          held_nxt  = held_r + CW'(1);
          state_nxt = S_FIN_LO;
        end
      end

      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = val_r;
        held_nxt  = held_r + CW'(1);
        state_nxt = S_FIN_LO;
      end

      S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = S_DEL_CMP;
      end

      // Walk up from the head; after the first match, move entries down
      S_DEL_CMP: begin
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (idx_r == last_idx) begin
          if (hit) begin
            held_nxt = held_m1;
          end else begin
            status_nxt = sli_pkg::ST_NOTFOUND;
          end
          state_nxt = S_FIN_LO;
        end else begin
          found_nxt = hit;
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_DEL_RD;
        end
      end

      // Fetch head then tail for the result
      S_FIN_LO: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_FIN_HI;
      end

      S_FIN_HI: begin
        small_nxt = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = last_idx;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      found_r <= found_nxt;
    end
    idx_r    <= idx_nxt;
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    small_r  <= small_nxt;
    status_r <= status_nxt;
  end

  // Checks
  `SLI_ASSERT(a_held_bound, clk, rst_n, held_r <= CW'(CAPACITY), "entry count above capacity")
  `SLI_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `SLI_ASSERT(a_held_step, clk, rst_n, (held_r != $past(held_r)) |-> ((held_r == $past(held_r) + CW'(1)) || (held_r == $past(held_r) - CW'(1))), "entry count moved by more than one")
  `SLI_ASSERT(a_full_status, clk, rst_n, (res_valid && (res_data.status == sli_pkg::ST_FULL)) |-> full, "full status with room left")
  `SLI_ASSERT(a_insert_grows, clk, rst_n, (res_valid && (cmd_r == sli_pkg::CMD_INSERT) && (status_r == sli_pkg::ST_DONE)) |-> (held_r != '0), "insert left list empty")

endmodule

[src/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed 32-bit values with insert and delete.
// ----------------------------------------------------------------------------
// An insert walks down from the tail, reading and then comparing each entry and
// moving each larger entry up a place until it finds the slot; a delete walks up
// from the head, reading and comparing each entry, and closes the gap behind the
// first match. The walk runs through an entry memory with one write port and one
// read port with registered read data, and two more reads fetch the head and tail
// for the result. A refused insert or an operation on an empty list skips the walk.
// No new beat is taken while an operation runs; a finished result waits in
// the output register and the next beat is accepted meanwhile.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sli_pkg::out_item_t out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                             res_valid;
  logic                             res_ready;
  sli_pkg::out_item_t               res_data;
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic signed [sli_pkg::VAL_W-1:0] mem_wdata;
  logic                             mem_re;
  logic [AW-1:0]                    mem_raddr;
  logic signed [sli_pkg::VAL_W-1:0] mem_rdata;

  logic               out_valid_r;
  sli_pkg::out_item_t out_data_r;

  sli_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sli_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a result when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
